[rtl/lav_pkg.sv]
// ----------------------------------------------------------------------------
// lav_pkg
// Shared widths, types and fixed-point helpers of the look-at view matrix.
// ----------------------------------------------------------------------------
package lav_pkg;

    // element and side-band widths
    localparam int Q_W    = 32;
    localparam int SIDE_W = 6 * Q_W;

    // normalizer datapath widths
    localparam int MAG_W  = 64;   // magnitude of a raw component
    localparam int SCL_W  = 30;   // block-scaled magnitude
    localparam int SQ_W   = 60;   // square of a scaled magnitude
    localparam int SUM_W  = 62;   // sum of three squares
    localparam int ROOT_W = 31;   // floor square root
    localparam int REM_W  = 33;   // square-root remainder
    localparam int NUM_W  = 61;   // dividend of a unit component
    localparam int QUO_W  = 31;   // unit component magnitude
    localparam int WIDE_W = 72;   // working width of rounding helpers

    localparam logic [1:0]        LAST_ROW = 2'd3;
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
    localparam logic signed [31:0] ZERO_Q16 = 32'sd0;

    typedef logic signed [MAG_W-1:0] c64_t;
    typedef logic signed [Q_W-1:0]   q32_t;
    typedef q32_t                    mat_t [4][3];

    // round to nearest, ties away from zero, shift right by sh (sh >= 1)
    function automatic logic signed [WIDE_W-1:0] rnd_shift(
        input logic signed [WIDE_W-1:0] v,
        input int unsigned              sh
    );
        logic [WIDE_W-1:0] mg;
        logic [WIDE_W-1:0] rn;
        mg = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
        rn = (mg + (WIDE_W'(1) << (sh - 1))) >> sh;
        return v[WIDE_W-1] ? -$signed(rn) : $signed(rn);
    endfunction

    // clamp to the signed 32-bit range
    function automatic q32_t sat32(input logic signed [WIDE_W-1:0] v);
        if (v > 72'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -72'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return $signed(v[Q_W-1:0]);
        end
    endfunction

endpackage

[rtl/lav_norm.sv]
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined vector normalizer: block scaling, squares, bit-per-stage square
// root and three bit-per-stage dividers; output is a Q2.30 unit vector.
// ----------------------------------------------------------------------------
module lav_norm #(
    parameter int SW = lav_pkg::SIDE_W
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  lav_pkg::c64_t in_c [3],
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output lav_pkg::q32_t out_q [3],
    output logic [SW-1:0] out_side
);
    import lav_pkg::*;

    localparam int RS = ROOT_W;
    localparam int DS = QUO_W;

    // stage 1: magnitudes
    logic [MAG_W-1:0] mg1_reg [3];
    logic [2:0]       ng1_reg;
    logic [SW-1:0]    sd1_reg;
    logic             v1_reg;
    // stage 2: largest magnitude
    logic [MAG_W-1:0] mx_next;
    logic [MAG_W-1:0] mx2_reg;
    logic [MAG_W-1:0] mg2_reg [3];
    logic [2:0]       ng2_reg;
    logic [SW-1:0]    sd2_reg;
    logic             v2_reg;
    // stage 3: leading one per byte
    logic [7:0]       any3_next;
    logic [2:0]       pos3_next [8];
    logic [7:0]       any3_reg;
    logic [2:0]       pos3_reg [8];
    logic [MAG_W-1:0] mg3_reg [3];
    logic [2:0]       ng3_reg;
    logic [SW-1:0]    sd3_reg;
    logic             v3_reg;
    // stage 4: shift counts
    logic [5:0]       msb_next;
    logic             zr_next;
    logic [5:0]       rsh_next;
    logic [4:0]       lsh_next;
    logic [5:0]       rsh4_reg;
    logic [4:0]       lsh4_reg;
    logic             zr4_reg;
    logic [MAG_W-1:0] mg4_reg [3];
    logic [2:0]       ng4_reg;
    logic [SW-1:0]    sd4_reg;
    logic             v4_reg;
    // stage 5: scaled magnitudes
    logic [SCL_W-1:0] m5_reg [3];
    logic             zr5_reg;
    logic [2:0]       ng5_reg;
    logic [SW-1:0]    sd5_reg;
    logic             v5_reg;
    // stage 6: squares
    logic [SQ_W-1:0]  sq6_reg [3];
    logic [SCL_W-1:0] m6_reg [3];
    logic             zr6_reg;
    logic [2:0]       ng6_reg;
    logic [SW-1:0]    sd6_reg;
    logic             v6_reg;

    // square-root stages; index 0 holds the sum of squares
    logic [REM_W-1:0]  sr_t [RS];
    logic [REM_W-1:0]  sr_trial [RS];
    logic [REM_W-1:0]  sr_rem_next [RS+1];
    logic [ROOT_W-1:0] sr_root_next [RS+1];
    logic [SUM_W-1:0]  sr_sum_next [RS+1];
    logic [REM_W-1:0]  sr_rem_reg [RS+1];
    logic [ROOT_W-1:0] sr_root_reg [RS+1];
    logic [SUM_W-1:0]  sr_sum_reg [RS+1];
    logic [SCL_W-1:0]  sr_m_reg [RS+1][3];
    logic              sr_zr_reg [RS+1];
    logic [2:0]        sr_ng_reg [RS+1];
    logic [SW-1:0]     sr_sd_reg [RS+1];
    logic              sr_v_reg [RS+1];

    // divider stages; index 0 holds the dividends
    logic [NUM_W-1:0]  dv_num [3];
    logic [ROOT_W:0]   dv_t [DS][3];
    logic              dv_ge [DS][3];
    logic [ROOT_W-1:0] dv_r_next [DS+1][3];
    logic [QUO_W-1:0]  dv_x_next [DS+1][3];
    logic [ROOT_W-1:0] dv_r_reg [DS+1][3];
    logic [QUO_W-1:0]  dv_x_reg [DS+1][3];
    logic [ROOT_W-1:0] dv_d_reg [DS+1];
    logic              dv_zr_reg [DS+1];
    logic [2:0]        dv_ng_reg [DS+1];
    logic [SW-1:0]     dv_sd_reg [DS+1];
    logic              dv_v_reg [DS+1];

    // output stage
    q32_t          q_reg [3];
    logic [SW-1:0] sdo_reg;
    logic          vo_reg;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            for (int k = 0; k <= RS; k++) sr_v_reg[k] <= 1'b0;
            for (int k = 0; k <= DS; k++) dv_v_reg[k] <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            sr_v_reg[0] <= v6_reg;
            for (int k = 0; k < RS; k++) sr_v_reg[k+1] <= sr_v_reg[k];
            dv_v_reg[0] <= sr_v_reg[RS];
            for (int k = 0; k < DS; k++) dv_v_reg[k+1] <= dv_v_reg[k];
            vo_reg <= dv_v_reg[DS];
        end
    end

    // front end: max, leading-one search, shift amounts
    always_comb begin
        mx_next = mg1_reg[0];
        if (mg1_reg[1] > mx_next) mx_next = mg1_reg[1];
        if (mg1_reg[2] > mx_next) mx_next = mg1_reg[2];
        for (int g = 0; g < 8; g++) begin
            any3_next[g] = |mx2_reg[8*g +: 8];
            pos3_next[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (mx2_reg[8*g + b]) pos3_next[g] = 3'(b);
            end
        end
        msb_next = 6'd0;
        zr_next  = 1'b1;
        for (int g = 0; g < 8; g++) begin
            if (any3_reg[g]) begin
                msb_next = {3'(g), pos3_reg[g]};
                zr_next  = 1'b0;
            end
        end
        if (msb_next >= 6'd30) begin
            rsh_next = msb_next - 6'd29;
            lsh_next = 5'd0;
        end else begin
            rsh_next = 6'd0;
            lsh_next = 5'(6'd29 - msb_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mg1_reg[i] <= in_c[i][MAG_W-1] ? MAG_W'(-in_c[i]) : MAG_W'(in_c[i]);
                ng1_reg[i] <= in_c[i][MAG_W-1];
            end
            sd1_reg <= in_side;

            mx2_reg <= mx_next;
            mg2_reg <= mg1_reg;
            ng2_reg <= ng1_reg;
            sd2_reg <= sd1_reg;

            any3_reg <= any3_next;
            pos3_reg <= pos3_next;
            mg3_reg  <= mg2_reg;
            ng3_reg  <= ng2_reg;
            sd3_reg  <= sd2_reg;

            rsh4_reg <= rsh_next;
            lsh4_reg <= lsh_next;
            zr4_reg  <= zr_next;
            mg4_reg  <= mg3_reg;
            ng4_reg  <= ng3_reg;
            sd4_reg  <= sd3_reg;

            for (int i = 0; i < 3; i++) begin
                m5_reg[i] <= SCL_W'((mg4_reg[i] >> rsh4_reg) << lsh4_reg);
            end
            zr5_reg <= zr4_reg;
            ng5_reg <= ng4_reg;
            sd5_reg <= sd4_reg;

            for (int i = 0; i < 3; i++) begin
                sq6_reg[i] <= m5_reg[i] * m5_reg[i];
            end
            m6_reg  <= m5_reg;
            zr6_reg <= zr5_reg;
            ng6_reg <= ng5_reg;
            sd6_reg <= sd5_reg;
        end
    end

    // square root, one result bit per stage
    always_comb begin
        sr_rem_next[0]  = '0;
        sr_root_next[0] = '0;
        sr_sum_next[0]  = SUM_W'(sq6_reg[0]) + SUM_W'(sq6_reg[1]) + SUM_W'(sq6_reg[2]);
        for (int k = 0; k < RS; k++) begin
            sr_t[k]     = {sr_rem_reg[k][REM_W-3:0], sr_sum_reg[k][SUM_W-1 -: 2]};
            sr_trial[k] = {sr_root_reg[k], 2'b01};
            if (sr_t[k] >= sr_trial[k]) begin
                sr_rem_next[k+1]  = sr_t[k] - sr_trial[k];
                sr_root_next[k+1] = {sr_root_reg[k][ROOT_W-2:0], 1'b1};
            end else begin
                sr_rem_next[k+1]  = sr_t[k];
                sr_root_next[k+1] = {sr_root_reg[k][ROOT_W-2:0], 1'b0};
            end
            sr_sum_next[k+1] = sr_sum_reg[k] << 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= RS; k++) begin
                sr_rem_reg[k]  <= sr_rem_next[k];
                sr_root_reg[k] <= sr_root_next[k];
                sr_sum_reg[k]  <= sr_sum_next[k];
            end
            sr_m_reg[0]  <= m6_reg;
            sr_zr_reg[0] <= zr6_reg;
            sr_ng_reg[0] <= ng6_reg;
            sr_sd_reg[0] <= sd6_reg;
            for (int k = 0; k < RS; k++) begin
                sr_m_reg[k+1]  <= sr_m_reg[k];
                sr_zr_reg[k+1] <= sr_zr_reg[k];
                sr_ng_reg[k+1] <= sr_ng_reg[k];
                sr_sd_reg[k+1] <= sr_sd_reg[k];
            end
        end
    end

    // division m * 2^30 / len, rounded, one quotient bit per stage
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dv_num[i] = NUM_W'({sr_m_reg[RS][i], 30'b0}) + NUM_W'(sr_root_reg[RS] >> 1);
            dv_r_next[0][i] = ROOT_W'(dv_num[i][NUM_W-1:QUO_W]);
            dv_x_next[0][i] = dv_num[i][QUO_W-1:0];
        end
        for (int j = 0; j < DS; j++) begin
            for (int i = 0; i < 3; i++) begin
                dv_t[j][i]  = {dv_r_reg[j][i], dv_x_reg[j][i][QUO_W-1]};
                dv_ge[j][i] = dv_t[j][i] >= {1'b0, dv_d_reg[j]};
                dv_r_next[j+1][i] = dv_ge[j][i] ?
                    ROOT_W'(dv_t[j][i] - {1'b0, dv_d_reg[j]}) : dv_t[j][i][ROOT_W-1:0];
                dv_x_next[j+1][i] = {dv_x_reg[j][i][QUO_W-2:0], dv_ge[j][i]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_r_reg <= dv_r_next;
            dv_x_reg <= dv_x_next;
            dv_d_reg[0]  <= sr_root_reg[RS];
            dv_zr_reg[0] <= sr_zr_reg[RS];
            dv_ng_reg[0] <= sr_ng_reg[RS];
            dv_sd_reg[0] <= sr_sd_reg[RS];
            for (int j = 0; j < DS; j++) begin
                dv_d_reg[j+1]  <= dv_d_reg[j];
                dv_zr_reg[j+1] <= dv_zr_reg[j];
                dv_ng_reg[j+1] <= dv_ng_reg[j];
                dv_sd_reg[j+1] <= dv_sd_reg[j];
            end
            // sign back; a zero vector stays zero
            for (int i = 0; i < 3; i++) begin
                if (dv_zr_reg[DS]) begin
                    q_reg[i] <= '0;
                end else if (dv_ng_reg[DS][i]) begin
                    q_reg[i] <= -$signed({1'b0, dv_x_reg[DS][i]});
                end else begin
                    q_reg[i] <= $signed({1'b0, dv_x_reg[DS][i]});
                end
            end
            sdo_reg <= dv_sd_reg[DS];
        end
    end

    assign out_valid = vo_reg;
    assign out_q     = q_reg;
    assign out_side  = sdo_reg;

endmodule

[rtl/lav_out.sv]
// ----------------------------------------------------------------------------
// lav_out
// Result register: holds one finished matrix and sends it row by row.
// ----------------------------------------------------------------------------
module lav_out (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               ld_valid,
    input  lav_pkg::mat_t      ld_mat,
    output logic               ld_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_row_index,
    output logic signed [31:0] m_col0,
    output logic signed [31:0] m_col1,
    output logic signed [31:0] m_col2,
    output logic signed [31:0] m_col3,
    output logic               m_last_row
);
    import lav_pkg::*;

    logic       ser_v_reg;
    logic [1:0] row_reg;
    mat_t       mat_reg;
    logic       load;

    // free now, or freed by the last row leaving this cycle
    assign ld_ready = !ser_v_reg || (m_ready && row_reg == LAST_ROW);
    assign load     = ld_valid && ld_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_v_reg <= 1'b0;
            row_reg   <= 2'd0;
        end else if (load) begin
            ser_v_reg <= 1'b1;
            row_reg   <= 2'd0;
        end else if (ser_v_reg && m_ready) begin
            row_reg <= row_reg + 2'd1;
            if (row_reg == LAST_ROW) ser_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) mat_reg <= ld_mat;
    end

    // row select
    always_comb begin
        unique case (row_reg)
            2'd0: begin
                m_col0 = mat_reg[0][0];
                m_col1 = mat_reg[0][1];
                m_col2 = mat_reg[0][2];
            end
            2'd1: begin
                m_col0 = mat_reg[1][0];
                m_col1 = mat_reg[1][1];
                m_col2 = mat_reg[1][2];
            end
            2'd2: begin
                m_col0 = mat_reg[2][0];
                m_col1 = mat_reg[2][1];
                m_col2 = mat_reg[2][2];
            end
            default: begin
                m_col0 = mat_reg[3][0];
                m_col1 = mat_reg[3][1];
                m_col2 = mat_reg[3][2];
            end
        endcase
    end

    assign m_valid     = ser_v_reg;
    assign m_row_index = row_reg;
    assign m_last_row  = (row_reg == LAST_ROW);
    assign m_col3      = (row_reg == LAST_ROW) ? ONE_Q16 : ZERO_Q16;

endmodule

[rtl/look_at_view_matrix.sv]
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Right-handed look-at view matrix in Q16.16, emitted as four rows.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake         | Payload
// s_      | in        | s_valid / s_ready | eye, target, up (x, y, z)
// m_      | out       | m_valid / m_ready | row_index, col0..col3, last_row
//
// An item enters every cycle the pipeline moves; each item gives four rows,
// one per cycle while m_ready is high. The first row passes the input
// stage, two 71-stage normalizers (31 square-root and 31 divider stages
// each), 7 product stages and the result register. Reset clears valid
// bits and the row counter only. A held result stalls the whole pipeline.
// ----------------------------------------------------------------------------
module look_at_view_matrix (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_eye_x,
    input  logic signed [31:0] s_eye_y,
    input  logic signed [31:0] s_eye_z,
    input  logic signed [31:0] s_target_x,
    input  logic signed [31:0] s_target_y,
    input  logic signed [31:0] s_target_z,
    input  logic signed [31:0] s_up_x,
    input  logic signed [31:0] s_up_y,
    input  logic signed [31:0] s_up_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_row_index,
    output logic signed [31:0] m_col0,
    output logic signed [31:0] m_col1,
    output logic signed [31:0] m_col2,
    output logic signed [31:0] m_col3,
    output logic               m_last_row
);
    import lav_pkg::*;

    logic adv;
    logic ld_ready;

    // stage 1: forward difference
    logic signed [32:0] d1_reg [3];
    q32_t               eye1_reg [3];
    q32_t               up1_reg [3];
    logic               v1_reg;
    c64_t               na_c [3];
    logic [SIDE_W-1:0]  na_side;
    logic               na_v;
    q32_t               fa_q [3];
    logic [SIDE_W-1:0]  sda;
    q32_t               eye_a [3];
    q32_t               up_a [3];

    // stages 2-3: up x f
    logic signed [63:0] p2_reg [6];
    q32_t               eye2_reg [3];
    q32_t               f2_reg [3];
    logic               v2_reg;
    c64_t               sc3_reg [3];
    q32_t               eye3_reg [3];
    q32_t               f3_reg [3];
    logic               v3_reg;
    logic [SIDE_W-1:0]  nb_side;
    logic               nb_v;
    q32_t               sb_q [3];
    logic [SIDE_W-1:0]  sdb;
    q32_t               eye_b [3];
    q32_t               f_b [3];

    // stages 4-8: f x s and dot products
    logic signed [63:0] fs4_reg [6];
    logic signed [63:0] se4_reg [3];
    logic signed [63:0] fe4_reg [3];
    q32_t               s4_reg [3];
    q32_t               f4_reg [3];
    q32_t               eye4_reg [3];
    logic               v4_reg;
    logic signed [63:0] ur5_reg [3];
    logic signed [65:0] sd5_reg;
    logic signed [65:0] fd5_reg;
    q32_t               s5_reg [3];
    q32_t               f5_reg [3];
    q32_t               eye5_reg [3];
    logic               v5_reg;
    logic signed [32:0] u6_reg [3];
    logic signed [65:0] sd6_reg;
    logic signed [65:0] fd6_reg;
    q32_t               s6_reg [3];
    q32_t               f6_reg [3];
    q32_t               eye6_reg [3];
    logic               v6_reg;
    logic signed [64:0] ue7_reg [3];
    logic signed [32:0] u7_reg [3];
    logic signed [65:0] sd7_reg;
    logic signed [65:0] fd7_reg;
    q32_t               s7_reg [3];
    q32_t               f7_reg [3];
    logic               v7_reg;
    logic signed [66:0] ud8_reg;
    logic signed [32:0] u8_reg [3];
    logic signed [65:0] sd8_reg;
    logic signed [65:0] fd8_reg;
    q32_t               s8_reg [3];
    q32_t               f8_reg [3];
    logic               v8_reg;
    mat_t               mat_next;

    // the pipeline moves unless a finished matrix cannot be handed over
    assign adv     = !v8_reg || ld_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= na_v;
            v3_reg <= v2_reg;
            v4_reg <= nb_v;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_reg[0]   <= 33'(s_eye_x) - 33'(s_target_x);
            d1_reg[1]   <= 33'(s_eye_y) - 33'(s_target_y);
            d1_reg[2]   <= 33'(s_eye_z) - 33'(s_target_z);
            eye1_reg[0] <= s_eye_x;
            eye1_reg[1] <= s_eye_y;
            eye1_reg[2] <= s_eye_z;
            up1_reg[0]  <= s_up_x;
            up1_reg[1]  <= s_up_y;
            up1_reg[2]  <= s_up_z;
        end
    end

    // side-band packing and unpacking around the normalizers
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            na_c[i] = 64'(d1_reg[i]);
            na_side[SIDE_W-1-Q_W*i -: Q_W]   = eye1_reg[i];
            na_side[SIDE_W/2-1-Q_W*i -: Q_W] = up1_reg[i];
            eye_a[i] = $signed(sda[SIDE_W-1-Q_W*i -: Q_W]);
            up_a[i]  = $signed(sda[SIDE_W/2-1-Q_W*i -: Q_W]);
            nb_side[SIDE_W-1-Q_W*i -: Q_W]   = eye3_reg[i];
            nb_side[SIDE_W/2-1-Q_W*i -: Q_W] = f3_reg[i];
            eye_b[i] = $signed(sdb[SIDE_W-1-Q_W*i -: Q_W]);
            f_b[i]   = $signed(sdb[SIDE_W/2-1-Q_W*i -: Q_W]);
        end
    end

    // forward axis
    lav_norm #(.SW(SIDE_W)) u_norm_f (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (v1_reg),
        .in_c     (na_c),
        .in_side  (na_side),
        .out_valid(na_v),
        .out_q    (fa_q),
        .out_side (sda)
    );

    // side axis, raw cross product
    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_reg[0] <= up_a[1] * fa_q[2];
            p2_reg[1] <= up_a[2] * fa_q[1];
            p2_reg[2] <= up_a[2] * fa_q[0];
            p2_reg[3] <= up_a[0] * fa_q[2];
            p2_reg[4] <= up_a[0] * fa_q[1];
            p2_reg[5] <= up_a[1] * fa_q[0];
            eye2_reg  <= eye_a;
            f2_reg    <= fa_q;

            sc3_reg[0] <= p2_reg[0] - p2_reg[1];
            sc3_reg[1] <= p2_reg[2] - p2_reg[3];
            sc3_reg[2] <= p2_reg[4] - p2_reg[5];
            eye3_reg   <= eye2_reg;
            f3_reg     <= f2_reg;
        end
    end

    lav_norm #(.SW(SIDE_W)) u_norm_s (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (v3_reg),
        .in_c     (sc3_reg),
        .in_side  (nb_side),
        .out_valid(nb_v),
        .out_q    (sb_q),
        .out_side (sdb)
    );

    // up axis and translation row
    always_ff @(posedge aclk) begin
        if (adv) begin
            fs4_reg[0] <= f_b[1] * sb_q[2];
            fs4_reg[1] <= f_b[2] * sb_q[1];
            fs4_reg[2] <= f_b[2] * sb_q[0];
            fs4_reg[3] <= f_b[0] * sb_q[2];
            fs4_reg[4] <= f_b[0] * sb_q[1];
            fs4_reg[5] <= f_b[1] * sb_q[0];
            for (int i = 0; i < 3; i++) begin
                se4_reg[i] <= sb_q[i] * eye_b[i];
                fe4_reg[i] <= f_b[i] * eye_b[i];
            end
            s4_reg   <= sb_q;
            f4_reg   <= f_b;
            eye4_reg <= eye_b;

            ur5_reg[0] <= fs4_reg[0] - fs4_reg[1];
            ur5_reg[1] <= fs4_reg[2] - fs4_reg[3];
            ur5_reg[2] <= fs4_reg[4] - fs4_reg[5];
            sd5_reg  <= 66'(se4_reg[0]) + 66'(se4_reg[1]) + 66'(se4_reg[2]);
            fd5_reg  <= 66'(fe4_reg[0]) + 66'(fe4_reg[1]) + 66'(fe4_reg[2]);
            s5_reg   <= s4_reg;
            f5_reg   <= f4_reg;
            eye5_reg <= eye4_reg;

            for (int i = 0; i < 3; i++) begin
                u6_reg[i] <= 33'(rnd_shift(72'(ur5_reg[i]), 30));
            end
            sd6_reg  <= sd5_reg;
            fd6_reg  <= fd5_reg;
            s6_reg   <= s5_reg;
            f6_reg   <= f5_reg;
            eye6_reg <= eye5_reg;

            for (int i = 0; i < 3; i++) begin
                ue7_reg[i] <= u6_reg[i] * eye6_reg[i];
            end
            u7_reg  <= u6_reg;
            sd7_reg <= sd6_reg;
            fd7_reg <= fd6_reg;
            s7_reg  <= s6_reg;
            f7_reg  <= f6_reg;

            ud8_reg <= 67'(ue7_reg[0]) + 67'(ue7_reg[1]) + 67'(ue7_reg[2]);
            u8_reg  <= u7_reg;
            sd8_reg <= sd7_reg;
            fd8_reg <= fd7_reg;
            s8_reg  <= s7_reg;
            f8_reg  <= f7_reg;
        end
    end

    // rounding to Q16.16 with saturation
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            mat_next[r][0] = sat32(rnd_shift(72'(s8_reg[r]), 14));
            mat_next[r][1] = sat32(rnd_shift(72'(u8_reg[r]), 14));
            mat_next[r][2] = sat32(rnd_shift(72'(f8_reg[r]), 14));
        end
        mat_next[3][0] = sat32(rnd_shift(-72'(sd8_reg), 30));
        mat_next[3][1] = sat32(rnd_shift(-72'(ud8_reg), 30));
        mat_next[3][2] = sat32(rnd_shift(-72'(fd8_reg), 30));
    end

    lav_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ld_valid   (v8_reg),
        .ld_mat     (mat_next),
        .ld_ready   (ld_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_row_index(m_row_index),
        .m_col0     (m_col0),
        .m_col1     (m_col1),
        .m_col2     (m_col2),
        .m_col3     (m_col3),
        .m_last_row (m_last_row)
    );

endmodule

[rtl/lav_checker.sv]
// ----------------------------------------------------------------------------
// lav_checker
// Port-level checks of the row sequence on the result channel.
// ----------------------------------------------------------------------------
module lav_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_row_index,
    input logic signed [31:0] m_col0,
    input logic signed [31:0] m_col3,
    input logic               m_last_row
);

    // last_row flags row 3 only
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_row == (m_row_index == 2'd3)))
        else $error("last_row does not match row index");

    // constant last column
    a_col3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_row ? (m_col3 == 32'sd65536) : (m_col3 == 32'sd0)))
        else $error("column 3 wrong");

    // rows of one matrix follow in order
    a_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_row) |=>
        (m_valid && m_row_index == 2'($past(m_row_index) + 2'd1)))
        else $error("row sequence broken");

    // a new matrix starts at row 0
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_row) |=> (!m_valid || m_row_index == 2'd0))
        else $error("matrix does not start at row 0");

    // stalled transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_row_index) && $stable(m_col0)))
        else $error("stalled transaction changed");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (.*);

[tb/sv/tb_look_at_view_matrix.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_look_at_view_matrix
// Drives eye, target and up vectors into the look-at block, predicts the four
// rows of each view matrix in fixed point and compares every row transaction.
// ----------------------------------------------------------------------------
module tb_look_at_view_matrix;
    import lav_pkg::*;

    localparam int WDOG_LIMIT = 20000;
    localparam int N_RANDOM   = 150;

    typedef struct packed {
        logic [1:0]         row;
        logic signed [31:0] c0, c1, c2, c3;
        logic               last;
    } row_t;

    typedef struct packed {
        logic signed [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz;
    } view_in_t;

    // directed row: stimulus, and the matrix where it is known at a glance
    typedef struct {
        view_in_t v;
        bit       known;
        mat_t     m;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_eye_x = '0, s_eye_y = '0, s_eye_z = '0;
    logic signed [31:0] s_target_x = '0, s_target_y = '0, s_target_z = '0;
    logic signed [31:0] s_up_x = '0, s_up_y = '0, s_up_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_row_index;
    logic signed [31:0] m_col0, m_col1, m_col2, m_col3;
    logic m_last_row;

    row_t rows_due[$];
    int   n_err = 0;
    int   quiet_cycles = 0;
    int   src_idle_pct = 0;
    int   snk_idle_pct = 0;
    bit   snk_hold = 1'b0;
    mat_t mat_none = '{default: '0};

    look_at_view_matrix dut (.*);

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] round_to(input logic signed [63:0] v, input int sh);
        logic [63:0] m;
        m = (mag(v) + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // unit vector in Q2.30 after block scaling
    task automatic unitize(input logic signed [63:0] c[3], output logic signed [63:0] q[3]);
        logic [63:0] m[3];
        logic [63:0] mx, sum, len, r;
        int sh, ls;
        mx = 0; sum = 0; sh = 0; ls = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag(c[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) q[i] = 0;
            return;
        end
        while ((mx >> sh) >= (64'd1 << 30)) sh++;
        if (sh == 0)
            while ((mx << ls) < (64'd1 << 29)) ls++;
        for (int i = 0; i < 3; i++) begin
            m[i] = (m[i] >> sh) << ls;
            sum += m[i] * m[i];
        end
        len = root64(sum);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++) begin
            r = ((m[i] << 30) + (len >> 1)) / len;
            q[i] = c[i][63] ? -$signed(r) : $signed(r);
        end
    endtask

    task automatic predict_view(input view_in_t v);
        logic signed [63:0] eye[3], up[3], d[3], f[3], sc[3], s[3], u[3];
        logic signed [31:0] cell_m[4][3];
        eye = '{v.ex, v.ey, v.ez};
        up  = '{v.ux, v.uy, v.uz};
        d   = '{64'(v.ex) - v.tx, 64'(v.ey) - v.ty, 64'(v.ez) - v.tz};
        unitize(d, f);
        sc[0] = up[1] * f[2] - up[2] * f[1];
        sc[1] = up[2] * f[0] - up[0] * f[2];
        sc[2] = up[0] * f[1] - up[1] * f[0];
        unitize(sc, s);
        u[0] = round_to(f[1] * s[2] - f[2] * s[1], 30);
        u[1] = round_to(f[2] * s[0] - f[0] * s[2], 30);
        u[2] = round_to(f[0] * s[1] - f[1] * s[0], 30);
        for (int i = 0; i < 3; i++) begin
            cell_m[i][0] = clamp32(round_to(s[i], 14));
            cell_m[i][1] = clamp32(round_to(u[i], 14));
            cell_m[i][2] = clamp32(round_to(f[i], 14));
        end
        cell_m[3][0] = clamp32(round_to(-(s[0]*eye[0] + s[1]*eye[1] + s[2]*eye[2]), 30));
        cell_m[3][1] = clamp32(round_to(-(u[0]*eye[0] + u[1]*eye[1] + u[2]*eye[2]), 30));
        cell_m[3][2] = clamp32(round_to(-(f[0]*eye[0] + f[1]*eye[1] + f[2]*eye[2]), 30));
        for (int r = 0; r < 4; r++)
            rows_due.push_back('{2'(r), cell_m[r][0], cell_m[r][1], cell_m[r][2],
                                (r == 3) ? ONE_Q16 : ZERO_Q16, r == 3});
    endtask

    // ---------------- stimulus ----------------
    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_view(input view_in_t v, input bit known, input mat_t exp_m);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        {s_eye_x, s_eye_y, s_eye_z, s_target_x, s_target_y, s_target_z,
         s_up_x, s_up_y, s_up_z} <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (known) begin
            for (int r = 0; r < 4; r++)
                rows_due.push_back('{2'(r), exp_m[r][0], exp_m[r][1], exp_m[r][2],
                                    (r == 3) ? ONE_Q16 : ZERO_Q16, r == 3});
        end else begin
            predict_view(v);
        end
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(2047)) << 16) >>> 4;
            3: return $signed($urandom_range(131072)) - 65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic view_in_t rand_view();
        view_in_t v;
        v = {rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
             rand_q(), rand_q(), rand_q()};
        case ($urandom_range(9))
            0: {v.tx, v.ty, v.tz} = {v.ex, v.ey, v.ez};       // eye on target
            1: {v.ux, v.uy, v.uz} = {v.ex - v.tx, v.ey - v.ty, v.ez - v.tz};
            2: {v.ux, v.uy, v.uz} = '0;
            default: ;
        endcase
        return v;
    endfunction

    localparam int N_DIRECTED = 10;
    localparam logic signed [31:0] QMAX = 32'sh7fffffff;
    localparam logic signed [31:0] QMIN = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sd65536;
    dir_row_t directed_tbl[N_DIRECTED] = '{
        // canonical camera: identity axes, translation -5 along z
        '{'{0, 0, ONE*5, 0, 0, 0, 0, ONE, 0}, 1'b1,
          '{'{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, ONE}, '{0, 0, -ONE*5}}},
        // eye on target: every axis and translation is zero
        '{'{ONE, ONE*2, ONE*3, ONE, ONE*2, ONE*3, 0, ONE, 0}, 1'b1,
          '{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}}},
        '{'{0, 0, ONE, 0, 0, 0, 0, 0, ONE}, 1'b0, '{default: '0}},  // up along forward
        '{'{0, 0, ONE, 0, 0, 0, 0, 0, 0}, 1'b0, '{default: '0}},    // zero up
        '{'{QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, 0, ONE, 0}, 1'b0, '{default: '0}},
        '{'{QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, QMAX, QMIN, QMAX}, 1'b0,
          '{default: '0}},
        '{'{QMAX, 1, 0, 0, 0, 0, 0, 0, QMIN}, 1'b0, '{default: '0}}, // tiny component dropped
        '{'{1, 0, 0, 0, 0, 0, 0, 1, 0}, 1'b0, '{default: '0}},
        '{'{-1, -1, -1, 0, 0, 0, -1, 0, 0}, 1'b0, '{default: '0}},
        '{'{32'sh5555aaaa, 32'shaaaa5555, 32'sh0f0f0f0f,
            32'shf0f0f0f0, 32'sh12345678, 32'sh87654321, 32'sh00ff00ff, -ONE, ONE},
          1'b0, '{default: '0}}
    };

    // ---------------- result checking ----------------
    always @(posedge aclk) begin
        row_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_row_index, m_col0, m_col1, m_col2, m_col3, m_last_row};
            if (rows_due.size() == 0) begin
                $display("%0t: unexpected row transaction %p", $time, got);
                n_err++;
            end else begin
                want = rows_due.pop_front();
                if (got != want) begin
                    $display("%0t: row mismatch expected %p actual %p", $time, want, got);
                    n_err++;
                end
            end
        end
    end

    // receiver ready with random stalls and an optional long hold-off
    always @(negedge aclk) begin
        m_ready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
    end

    // watchdog on accepted transactions
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("tb_look_at_view_matrix: errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_tbl[i])
            send_view(directed_tbl[i].v, directed_tbl[i].known, directed_tbl[i].m);

        // long receiver hold-off while the sender keeps offering; intake stops
        // once a second finished matrix waits behind the held one
        snk_hold = 1'b1;
        src_idle_pct = 75;
        fork
            begin
                repeat (400) @(posedge aclk);
                snk_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 60; i++) send_view(rand_view(), 1'b0, mat_none);
                s_valid <= 1'b0;
            end
        join

        // sender pauses until the pipeline drains
        while (rows_due.size() != 0) @(posedge aclk);
        @(negedge aclk);

        src_idle_pct = 34; snk_idle_pct = 51;
        for (int i = 0; i < N_RANDOM / 3; i++) send_view(rand_view(), 1'b0, mat_none);
        src_idle_pct = 51; snk_idle_pct = 34;
        for (int i = 0; i < N_RANDOM / 3; i++) send_view(rand_view(), 1'b0, mat_none);
        src_idle_pct = 0; snk_idle_pct = 0;
        for (int i = 0; i < N_RANDOM / 3; i++) send_view(rand_view(), 1'b0, mat_none);
        s_valid <= 1'b0;

        while (rows_due.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (n_err == 0)
            $display("tb_look_at_view_matrix: clean");
        else
            $display("tb_look_at_view_matrix: errors");
        $finish;
    end

endmodule
